// ===== rtl/irbt_pkg.sv =====
// ----------------------------------------------------------------------------
// irbt_pkg
// Shared types, constants and the command code map of the IR button translator.
// ----------------------------------------------------------------------------
package irbt_pkg;

  localparam int OUT_BUTTONS = 17;
  localparam int TIME_W      = 32;
  localparam int REG_W       = 16;
  localparam int ADDR_W      = 16;
  localparam int CODE_W      = 16;
  localparam int BTN_W       = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_REPEAT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_A      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_B      = 3'd5;

  localparam logic [REG_W-1:0] HOLD_RESET        = 16'd100;
  localparam logic [REG_W-1:0] BLOCK_RESET       = 16'd50;
  localparam logic [REG_W-1:0] MODE_REPEAT_RESET = 16'd500;
  localparam logic [REG_W-1:0] BLINK_RESET       = 16'd1000;
  localparam logic [REG_W-1:0] ADDR_A_RESET      = 16'h00F4;
  localparam logic [REG_W-1:0] ADDR_B_RESET      = 16'h0074;

  localparam logic [CODE_W-1:0] KEY_RECORD = 16'h0017;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_TRANS = 2'd1,
    MODE_PASS  = 2'd2
  } mode_t;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now_ms;
    logic [ADDR_W-1:0] ir_address;
    logic [CODE_W-1:0] ir_command;
  } poll_t;

  typedef struct packed {
    logic [OUT_BUTTONS-1:0] buttons_n;
    logic                   led_on;
    logic [1:0]             mode;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_BTN,
    ST_KEY,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic scan_rd;
    logic scan_end;
    logic btn_chk;
    logic key_chk;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } ctrl_status_t;

  // button for a command code, zero for none
  function automatic logic [BTN_W-1:0] map_button(input logic [CODE_W-1:0] code,
                                                  input logic              pass);
    logic [BTN_W-1:0] b;
    b = '0;
    case (code)
      16'h0016: b = 4'd5;
      16'h0019: b = 4'd6;
      16'h001B: b = 4'd1;
      16'h001A: b = 4'd2;
      16'h0051: b = 4'd3;
      16'h000F: b = 4'd4;
      16'h0015: b = 4'd7;
      16'h0014: b = 4'd8;
      16'h004F: b = 4'd11;
      16'h0018: b = 4'd12;
      16'h0024: b = 4'd10;
      default:  b = '0;
    endcase
    if (b == '0 && pass) begin
      case (code)
        16'h0020: b = 4'd1;
        16'h0021: b = 4'd2;
        16'h001E: b = 4'd3;
        16'h001F: b = 4'd4;
        16'h0022: b = 4'd5;
        16'h0023: b = 4'd9;
        16'h0066: b = 4'd5;
        16'h0025: b = 4'd6;
        16'h0068: b = 4'd11;
        16'h0026: b = 4'd12;
        default:  b = '0;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== rtl/ir_remote_button_translator.sv =====
// ----------------------------------------------------------------------------
// ir_remote_button_translator
// Turns polls with optional decoded IR frames into active-low button bits,
// a status LED level and a three-state control mode.
// ----------------------------------------------------------------------------
// A request is worked through in order: the walk over the press time memory,
// which reads one button entry per cycle, then the release check of the last
// entry and the LED update, followed by the mapped button check, the record
// key check and the output load. One request is in work at a time; a new one
// is taken once the previous result has moved into the output register, even
// while that result is still stalled. A result stalled when the next one is
// ready holds the sequencer until it leaves. Configuration must be written
// only while no request is in work; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module ir_remote_button_translator #(
  parameter int NUM_BUTTONS = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           poll_valid,
  output logic                           poll_stall,
  input  irbt_pkg::poll_t                poll,
  output logic                           result_valid,
  input  logic                           result_stall,
  output irbt_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [irbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irbt_pkg::REG_W-1:0]     cfg_data
);
  import irbt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  irbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .poll_valid(poll_valid),
    .poll_stall(poll_stall),
    .status    (status),
    .cmd       (cmd)
  );

  irbt_datapath #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .poll        (poll),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ===== rtl/irbt_ram.sv =====
// ----------------------------------------------------------------------------
// irbt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module irbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/irbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// irbt_ctrl
// Sequencer: takes a request, walks the press times, checks the mapped
// button and the record key, then hands the result to the output register.
// ----------------------------------------------------------------------------
module irbt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   poll_valid,
  output logic                   poll_stall,
  input  irbt_pkg::ctrl_status_t status,
  output irbt_pkg::ctrl_cmd_t    cmd
);
  import irbt_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (poll_valid) state_next = ST_SCAN;
      ST_SCAN:     if (status.scan_last) state_next = ST_SCAN_END;
      ST_SCAN_END: state_next = ST_BTN;
      ST_BTN:      state_next = ST_KEY;
      ST_KEY:      state_next = ST_DONE;
      ST_DONE:     if (!status.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    poll_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        poll_stall = 1'b0;
        cmd.take   = poll_valid;
      end
      ST_SCAN:     cmd.scan_rd  = 1'b1;
      ST_SCAN_END: cmd.scan_end = 1'b1;
      ST_BTN:      cmd.btn_chk  = 1'b1;
      ST_KEY:      cmd.key_chk  = 1'b1;
      ST_DONE:     cmd.load_out = !status.out_busy;
      default:     cmd = '0;
    endcase
  end

endmodule

// ===== rtl/irbt_datapath.sv =====
// ----------------------------------------------------------------------------
// irbt_datapath
// Configuration registers, press time memory, button bits, mode, LED blink
// and the output register.
// ----------------------------------------------------------------------------
module irbt_datapath #(
  parameter int NUM_BUTTONS = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [irbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irbt_pkg::REG_W-1:0]      cfg_data,
  input  irbt_pkg::poll_t                 poll,
  output irbt_pkg::result_t               result,
  output logic                            result_valid,
  input  logic                            result_stall,
  input  irbt_pkg::ctrl_cmd_t             cmd,
  output irbt_pkg::ctrl_status_t          status
);
  import irbt_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUTTONS);

  logic [REG_W-1:0]       hold_ms, block_ms, mode_rep_ms, blink_ms, addr_a, addr_b;
  poll_t                  poll_q;
  logic [IDX_W-1:0]       cnt;
  logic                   pend;
  logic [IDX_W-1:0]       rd_idx;
  logic [TIME_W-1:0]      rd_data;
  logic [NUM_BUTTONS-1:0] vld;
  logic [NUM_BUTTONS-1:0] bits;
  logic                   led;
  logic                   phase;
  logic [TIME_W-1:0]      last_blink;
  mode_t                  mode;

  logic                   frame_hit, btn_hit, key_hit;
  logic [BTN_W-1:0]       btn_code;
  logic [IDX_W-1:0]       btn_idx;
  logic [IDX_W-1:0]       rd_addr;
  logic [TIME_W-1:0]      time_cur;
  logic [REG_W-1:0]       limit;
  logic [TIME_W:0]        deadline;
  logic                   expired;
  logic                   release_hit, btn_press, key_press;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [TIME_W-1:0]      elapsed;
  logic [OUT_BUTTONS-1:0] out_bits;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms     <= HOLD_RESET;
      block_ms    <= BLOCK_RESET;
      mode_rep_ms <= MODE_REPEAT_RESET;
      blink_ms    <= BLINK_RESET;
      addr_a      <= ADDR_A_RESET;
      addr_b      <= ADDR_B_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD:        hold_ms     <= cfg_data;
        REG_BLOCK:       block_ms    <= cfg_data;
        REG_MODE_REPEAT: mode_rep_ms <= cfg_data;
        REG_BLINK:       blink_ms    <= cfg_data;
        REG_ADDR_A:      addr_a      <= cfg_data;
        REG_ADDR_B:      addr_b      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign frame_hit = poll_q.command &&
                     (poll_q.ir_address == addr_a || poll_q.ir_address == addr_b);
  assign btn_code  = map_button(poll_q.ir_command, mode == MODE_PASS);
  assign btn_idx   = IDX_W'(btn_code);
  assign btn_hit   = frame_hit && mode != MODE_OFF && btn_code != '0;
  assign key_hit   = frame_hit && poll_q.ir_command == KEY_RECORD;

  always_comb begin
    priority if (cmd.scan_rd) begin
      rd_addr = cnt;
    end else if (cmd.scan_end) begin
      rd_addr = btn_idx;
    end else begin
      rd_addr = '0;
    end
  end

  // one shared add and compare for release and press checks
  assign time_cur = vld[rd_idx] ? rd_data : '0;
  assign limit    = pend ? hold_ms : (cmd.btn_chk ? block_ms : mode_rep_ms);
  assign deadline = {1'b0, time_cur} + {{(TIME_W - REG_W + 1){1'b0}}, limit};
  assign expired  = deadline[TIME_W-1:0] < poll_q.now_ms;

  assign release_hit = pend && expired;
  assign btn_press   = cmd.btn_chk && btn_hit && expired;
  assign key_press   = cmd.key_chk && key_hit && expired;
  assign ram_we      = btn_press || key_press;
  assign ram_waddr   = btn_press ? btn_idx : '0;

  assign elapsed = poll_q.now_ms - last_blink;

  irbt_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NUM_BUTTONS)
  ) u_press_time (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(poll_q.now_ms),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      poll_q <= poll;
    end
    rd_idx <= rd_addr;
    if (cmd.load_out) begin
      result.buttons_n <= out_bits;
      result.led_on    <= led;
      result.mode      <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      pend         <= 1'b0;
      vld          <= '0;
      bits         <= '1;
      mode         <= MODE_TRANS;
      led          <= 1'b0;
      phase        <= 1'b1;
      last_blink   <= '0;
      result_valid <= 1'b0;
    end else begin
      pend <= cmd.scan_rd;
      if (cmd.take) begin
        cnt <= '0;
      end else if (cmd.scan_rd) begin
        cnt <= IDX_W'(cnt + 1'b1);
      end

      // release, the mode key keeps its time
      if (release_hit) begin
        bits[rd_idx] <= 1'b1;
        if (rd_idx != '0) begin
          vld[rd_idx] <= 1'b0;
        end
      end
      if (btn_press) begin
        bits[btn_idx] <= 1'b0;
        vld[btn_idx]  <= 1'b1;
      end
      if (key_press) begin
        bits[0] <= 1'b0;
        vld[0]  <= 1'b1;
        unique case (mode)
          MODE_OFF:   mode <= MODE_TRANS;
          MODE_TRANS: mode <= MODE_PASS;
          MODE_PASS:  mode <= MODE_OFF;
          default:    mode <= MODE_TRANS;
        endcase
      end

      if (cmd.scan_end) begin
        unique case (mode)
          MODE_TRANS: begin
            if (elapsed > {{(TIME_W - REG_W){1'b0}}, blink_ms}) begin
              led        <= phase;
              phase      <= ~phase;
              last_blink <= poll_q.now_ms;
            end
          end
          MODE_OFF:  led <= 1'b0;
          MODE_PASS: led <= 1'b1;
          default: ;
        endcase
      end

      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  for (genvar j = 0; j < OUT_BUTTONS; j++) begin : g_out
    if (j < NUM_BUTTONS) begin : g_used
      assign out_bits[j] = bits[j];
    end else begin : g_unused
      assign out_bits[j] = 1'b1;
    end
  end

  assign status.scan_last = cnt == IDX_W'(NUM_BUTTONS - 1);
  assign status.out_busy  = result_valid && result_stall;

  // mode key time is never dropped once written
  a_key_time_kept: assert property (@(posedge clk) disable iff (rst)
    vld[0] |=> vld[0])
    else $error("mode key press time lost");

  a_mode_only_on_key: assert property (@(posedge clk) disable iff (rst)
    !cmd.key_chk |=> $stable(mode))
    else $error("mode changed outside key check");

  a_press_only_on_check: assert property (@(posedge clk) disable iff (rst)
    !(cmd.btn_chk || cmd.key_chk) |=> (($past(bits) & ~bits) == '0))
    else $error("button pressed outside press check");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("loaded result not presented");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IR remote button translator. Polls go in over
// the valid/stall request channel with random gaps; results come back under
// random stall. A tracker keeps its own copy of mode, press times, button bits
// and LED blink state, computes the expected result of every accepted poll
// and compares each returned result field by field. The run covers the
// default settings and several register sets, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import irbt_pkg::*;

  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int NUM_PHASES       = 6;
  localparam int NUM_REGS         = int'(REG_ADDR_B) + 1;
  localparam int NUM_CODES        = 22;
  localparam int NUM_COMMON       = 11;
  localparam int REPORT_MAX       = 10;

  // codes seen in both active modes, then passthrough only, then the record key
  localparam logic [CODE_W-1:0] CODE_LIST [NUM_CODES] = '{
    16'h0016, 16'h0019, 16'h001B, 16'h001A, 16'h0051, 16'h000F,
    16'h0015, 16'h0014, 16'h004F, 16'h0018, 16'h0024,
    16'h0020, 16'h0021, 16'h001E, 16'h001F, 16'h0022, 16'h0023,
    16'h0066, 16'h0025, 16'h0068, 16'h0026,
    KEY_RECORD
  };

  class button_tracker;
    mode_t                  mode;
    logic [TIME_W-1:0]      press_ms [OUT_BUTTONS];
    logic [OUT_BUTTONS-1:0] buttons_n;
    logic                   led;
    logic                   blink_next;
    logic [TIME_W-1:0]      blink_ms;
    logic [REG_W-1:0]       hold_ms;
    logic [REG_W-1:0]       block_ms;
    logic [REG_W-1:0]       mode_block_ms;
    logic [REG_W-1:0]       blink_period;
    logic [REG_W-1:0]       addr_a;
    logic [REG_W-1:0]       addr_b;
    result_t                expected_panels [$];
    int                     mismatches;

    function new();
      mismatches = 0;
      mode = MODE_TRANS;
      foreach (press_ms[i]) press_ms[i] = '0;
      buttons_n = '1;
      led = 1'b0;
      blink_next = 1'b1;
      blink_ms = '0;
      hold_ms = HOLD_RESET;
      block_ms = BLOCK_RESET;
      mode_block_ms = MODE_REPEAT_RESET;
      blink_period = BLINK_RESET;
      addr_a = ADDR_A_RESET;
      addr_b = ADDR_B_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] v);
      case (idx)
        REG_HOLD:        hold_ms = v;
        REG_BLOCK:       block_ms = v;
        REG_MODE_REPEAT: mode_block_ms = v;
        REG_BLINK:       blink_period = v;
        REG_ADDR_A:      addr_a = v;
        REG_ADDR_B:      addr_b = v;
        default: ;
      endcase
    endfunction

    function int button_for(logic [CODE_W-1:0] code, bit passthrough);
      int b;
      b = 0;
      for (int i = 0; i < NUM_COMMON; i++)
        if (code == CODE_LIST[i]) b = (i == 0) ? 5 : (i == 1) ? 6 : (i == 2) ? 1 :
                                     (i == 3) ? 2 : (i == 4) ? 3 : (i == 5) ? 4 :
                                     (i == 6) ? 7 : (i == 7) ? 8 : (i == 8) ? 11 :
                                     (i == 9) ? 12 : 10;
      if (b == 0 && passthrough) begin
        case (code)
          16'h0020: b = 1;
          16'h0021: b = 2;
          16'h001E: b = 3;
          16'h001F: b = 4;
          16'h0022: b = 5;
          16'h0023: b = 9;
          16'h0066: b = 5;
          16'h0025: b = 6;
          16'h0068: b = 11;
          16'h0026: b = 12;
          default:  b = 0;
        endcase
      end
      return b;
    endfunction

    function bit try_press(int b, logic [TIME_W-1:0] lim, logic [TIME_W-1:0] t_ms);
      logic [TIME_W-1:0] due;
      due = press_ms[b] + lim;
      if (due < t_ms) begin
        buttons_n[b] = 1'b0;
        press_ms[b] = t_ms;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_poll(poll_t p);
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] since;
      int b;
      result_t r;
      if (mode == MODE_TRANS) begin
        since = p.now_ms - blink_ms;
        if (since > {16'b0, blink_period}) begin
          led = blink_next;
          blink_next = ~blink_next;
          blink_ms = p.now_ms;
        end
      end else if (mode == MODE_OFF) begin
        led = 1'b0;
      end else if (mode == MODE_PASS) begin
        led = 1'b1;
      end
      for (int i = 0; i < OUT_BUTTONS; i++) begin
        due = press_ms[i] + {16'b0, hold_ms};
        if (due < p.now_ms) begin
          buttons_n[i] = 1'b1;
          // the record key keeps its time so the mode block still holds
          if (i != 0) press_ms[i] = '0;
        end
      end
      if (p.command && (p.ir_address == addr_a || p.ir_address == addr_b)) begin
        if (mode != MODE_OFF) begin
          b = button_for(p.ir_command, mode == MODE_PASS);
          if (b != 0) void'(try_press(b, {16'b0, block_ms}, p.now_ms));
        end
        if (p.ir_command == KEY_RECORD && try_press(0, {16'b0, mode_block_ms}, p.now_ms)) begin
          case (mode)
            MODE_OFF:   mode = MODE_TRANS;
            MODE_TRANS: mode = MODE_PASS;
            MODE_PASS:  mode = MODE_OFF;
            default: ;
          endcase
        end
      end
      r.buttons_n = buttons_n;
      r.led_on = led;
      r.mode = mode;
      expected_panels.push_back(r);
    endfunction

    function void check_panel(result_t got);
      result_t want;
      if (expected_panels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: buttons_n %h led %b mode %0d",
                   got.buttons_n, got.led_on, got.mode);
        return;
      end
      want = expected_panels.pop_front();
      if (got.buttons_n !== want.buttons_n || got.led_on !== want.led_on ||
          got.mode !== want.mode) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: buttons_n %h/%h led %b/%b mode %0d/%0d (expected/actual)",
                   want.buttons_n, got.buttons_n, want.led_on, got.led_on,
                   want.mode, got.mode);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 poll_valid;
  logic                 poll_stall;
  poll_t                poll;
  logic                 result_valid;
  logic                 result_stall;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  button_tracker        tracker;
  logic [TIME_W-1:0]    clock_ms;
  logic [REG_W-1:0]     cfg_vals [NUM_REGS];
  bit                   quiet;
  int                   stall_left;
  int                   cycle_count;

  ir_remote_button_translator u_top (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short runs, a few long ones
  function automatic int pick_run();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic poll_t make_poll(logic cmd, logic [TIME_W-1:0] t_ms,
                                      logic [ADDR_W-1:0] addr, logic [CODE_W-1:0] code);
    poll_t p;
    p.command = cmd;
    p.now_ms = t_ms;
    p.ir_address = addr;
    p.ir_command = code;
    return p;
  endfunction

  function automatic poll_t next_random_poll();
    int r;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] code;
    r = $urandom_range(0, 99);
    if (r < 4) clock_ms = $urandom;
    else if (r < 6) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else if (r < 8) clock_ms = clock_ms + $urandom_range(0, 70000);
    else clock_ms = clock_ms + $urandom_range(0, 120);
    r = $urandom_range(0, 19);
    if (r < 8) addr = tracker.addr_a;
    else if (r < 16) addr = tracker.addr_b;
    else if (r < 18) addr = ADDR_W'($urandom_range(0, 65535));
    else addr = tracker.addr_a ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
    r = $urandom_range(0, 19);
    if (r < 12) code = CODE_LIST[$urandom_range(0, NUM_CODES - 1)];
    else if (r < 16) code = KEY_RECORD;
    else code = CODE_W'($urandom_range(0, 65535));
    return make_poll($urandom_range(0, 9) < 7, clock_ms, addr, code);
  endfunction

  task automatic send_poll(input poll_t p);
    int gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_run();
    if (gap > 0) begin
      poll_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_valid <= 1'b1;
    poll <= p;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    tracker.take_poll(p);
  endtask

  task automatic drain();
    poll_valid <= 1'b0;
    while (tracker.expected_panels.size() != 0) @(posedge clk);
  endtask

  task automatic write_config();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= cfg_vals[i];
      @(posedge clk);
      tracker.write_reg(CFG_IDX_W'(i), cfg_vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config(input int ph);
    case (ph)
      0: begin
        cfg_vals[REG_HOLD] = '0;
        cfg_vals[REG_BLOCK] = '0;
        cfg_vals[REG_MODE_REPEAT] = '0;
        cfg_vals[REG_BLINK] = '0;
        cfg_vals[REG_ADDR_A] = '0;
        cfg_vals[REG_ADDR_B] = '1;
      end
      1: begin
        cfg_vals[REG_HOLD] = '1;
        cfg_vals[REG_BLOCK] = '1;
        cfg_vals[REG_MODE_REPEAT] = '1;
        cfg_vals[REG_BLINK] = '1;
        cfg_vals[REG_ADDR_A] = '1;
        cfg_vals[REG_ADDR_B] = '0;
      end
      2: begin
        cfg_vals[REG_HOLD] = HOLD_RESET;
        cfg_vals[REG_BLOCK] = BLOCK_RESET;
        cfg_vals[REG_MODE_REPEAT] = MODE_REPEAT_RESET;
        cfg_vals[REG_BLINK] = BLINK_RESET;
        cfg_vals[REG_ADDR_A] = ADDR_A_RESET;
        cfg_vals[REG_ADDR_B] = ADDR_B_RESET;
      end
      default: begin
        cfg_vals[REG_HOLD] = REG_W'($urandom_range(0, 400));
        cfg_vals[REG_BLOCK] = REG_W'($urandom_range(0, 200));
        cfg_vals[REG_MODE_REPEAT] = REG_W'($urandom_range(0, 1000));
        cfg_vals[REG_BLINK] = REG_W'($urandom_range(0, 500));
        cfg_vals[REG_ADDR_A] = REG_W'($urandom_range(0, 65535));
        cfg_vals[REG_ADDR_B] = REG_W'($urandom_range(0, 65535));
      end
    endcase
  endtask

  // result side: check accepted results and stall at random
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) tracker.check_panel(result);
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = pick_run() - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    tracker = new();
    quiet = 1'b0;
    stall_left = 0;
    clock_ms = '0;
    rst <= 1'b1;
    poll_valid <= 1'b0;
    poll <= '0;
    result_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // time poll only, frame fields ignored
    send_poll(make_poll(1'b0, clock_ms, '1, '1));
    // common codes in translation mode
    for (int i = 0; i < NUM_COMMON; i++) begin
      clock_ms = clock_ms + 60;
      send_poll(make_poll(1'b1, clock_ms, (i % 2 == 0) ? ADDR_A_RESET : ADDR_B_RESET,
                          CODE_LIST[i]));
    end
    clock_ms = clock_ms + 60;
    send_poll(make_poll(1'b1, clock_ms, ADDR_A_RESET, KEY_RECORD));
    // passthrough-only codes
    for (int i = NUM_COMMON; i < NUM_CODES - 1; i++) begin
      clock_ms = clock_ms + 60;
      send_poll(make_poll(1'b1, clock_ms, (i % 2 == 0) ? ADDR_A_RESET : ADDR_B_RESET,
                          CODE_LIST[i]));
    end
    // other address ignored
    send_poll(make_poll(1'b1, clock_ms + 200, ~ADDR_A_RESET, CODE_LIST[0]));
    // time stamp wrap
    send_poll(make_poll(1'b1, 32'hFFFF_FFF0, ADDR_A_RESET, CODE_LIST[1]));
    clock_ms = 32'h0000_0010;
    send_poll(make_poll(1'b1, clock_ms, ADDR_B_RESET, CODE_LIST[2]));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick_config(ph);
      write_config();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_poll(next_random_poll());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_panels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
